>>> hw/rtl/eth_ipv4_l4_header_parser_top_assert.svh
// Assertion macros for the header parser checker
`ifndef ETH_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH
`define ETH_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH

// clocked assertion with synchronous active-low reset disable
`define EHP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same, on the block clock and reset
`define EHP_ASSERT_CLK(lbl, prop, msg) `EHP_ASSERT(lbl, i_clk, i_rst_n, prop, msg)

`endif

>>> hw/rtl/ehp_pkg.sv
// Shared types and constants for the Ethernet/IPv4/L4 header parser
`timescale 1ns / 1ps

package ehp_pkg;

    localparam int unsigned CntW   = 17;
    localparam int unsigned FlenW  = CntW + 1;
    localparam int unsigned QDepth = 2;
    localparam int unsigned QPtrW  = $clog2(QDepth);
    localparam int unsigned QCntW  = QPtrW + 1;

    localparam logic [CntW-1:0] COUNT_MAX  = '1;
    localparam logic [CntW-1:0] POS_VER    = 17'd14;
    localparam logic [CntW-1:0] POS_TOT_HI = 17'd16;
    localparam logic [CntW-1:0] POS_TOT_LO = 17'd17;
    localparam logic [CntW-1:0] POS_PROTO  = 17'd23;

    localparam logic [6:0]       ETH_LEN   = 7'd14;
    localparam logic [5:0]       IP_MIN    = 6'd20;
    localparam logic [5:0]       L4_SHORT  = 6'd8;
    localparam logic [FlenW-1:0] MIN_FRAME = 18'd34;
    localparam logic [3:0]       IP_V4     = 4'd4;

    localparam logic [7:0] PROT_ICMP = 8'd1;
    localparam logic [7:0] PROT_TCP  = 8'd6;
    localparam logic [7:0] PROT_UDP  = 8'd17;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_SHORT_FRAME   = 3'd1,
        ST_NOT_V4        = 3'd2,
        ST_BAD_IHL       = 3'd3,
        ST_BAD_TOTAL     = 3'd4,
        ST_SHORT_L4      = 3'd5,
        ST_UNKNOWN_PROTO = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0]       ver_ihl;
        logic [15:0]      total;
        logic [7:0]       proto;
        logic [15:0]      src;
        logic [15:0]      dst;
        logic [7:0]       mtype;
        logic [7:0]       mcode;
        logic [3:0]       doff;
        logic [FlenW-1:0] flen;
    } t_frame_rec;

    typedef struct packed {
        logic full;
        logic not_empty;
    } t_q_stat;

endpackage

>>> hw/rtl/ehp_front.sv
// Front end: byte counter and header field capture, one record per frame
`timescale 1ns / 1ps

module ehp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    input  ehp_pkg::t_q_stat    i_q_stat,
    output logic                o_ready,
    output logic                o_push,
    output ehp_pkg::t_frame_rec o_rec
);

    logic [ehp_pkg::CntW-1:0] r_count, n_count;
    logic [7:0]  r_ver_ihl, n_ver_ihl;
    logic [15:0] r_total, n_total;
    logic [7:0]  r_proto, n_proto;
    logic [15:0] r_src, n_src;
    logic [15:0] r_dst, n_dst;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_code, n_code;
    logic [3:0]  r_doff, n_doff;
    logic [6:0]  w_t;
    logic        w_accept;

    assign o_ready  = !i_q_stat.full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && i_last_byte;
    assign w_t      = ehp_pkg::ETH_LEN + {1'b0, r_ver_ihl[3:0], 2'b00};

    always_comb begin
        n_ver_ihl = r_ver_ihl;
        n_total   = r_total;
        n_proto   = r_proto;
        n_src     = r_src;
        n_dst     = r_dst;
        n_type    = r_type;
        n_code    = r_code;
        n_doff    = r_doff;
        if (r_count == ehp_pkg::POS_VER) begin
            n_ver_ihl = i_data_byte;
        end
        if (r_count == ehp_pkg::POS_TOT_HI) begin
            n_total[15:8] = i_data_byte;
        end
        if (r_count == ehp_pkg::POS_TOT_LO) begin
            n_total[7:0] = i_data_byte;
        end
        if (r_count == ehp_pkg::POS_PROTO) begin
            n_proto = i_data_byte;
        end
        if (r_count > ehp_pkg::POS_VER) begin
            if (r_count == {10'd0, w_t}) begin
                n_src[15:8] = i_data_byte;
                n_type      = i_data_byte;
            end
            if (r_count == {10'd0, w_t + 7'd1}) begin
                n_src[7:0] = i_data_byte;
                n_code     = i_data_byte;
            end
            if (r_count == {10'd0, w_t + 7'd2}) begin
                n_dst[15:8] = i_data_byte;
            end
            if (r_count == {10'd0, w_t + 7'd3}) begin
                n_dst[7:0] = i_data_byte;
            end
            if (r_count == {10'd0, w_t + 7'd12}) begin
                n_doff = i_data_byte[7:4];
            end
        end
        n_count = (r_count != ehp_pkg::COUNT_MAX) ? r_count + 17'd1 : r_count;
    end

    always_comb begin
        o_rec.ver_ihl = n_ver_ihl;
        o_rec.total   = n_total;
        o_rec.proto   = n_proto;
        o_rec.src     = n_src;
        o_rec.dst     = n_dst;
        o_rec.mtype   = n_type;
        o_rec.mcode   = n_code;
        o_rec.doff    = n_doff;
        o_rec.flen    = {1'b0, r_count} + 18'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count   <= '0;
            r_ver_ihl <= '0;
            r_total   <= '0;
            r_proto   <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_type    <= '0;
            r_code    <= '0;
            r_doff    <= '0;
        end else if (w_accept) begin
            r_count   <= n_count;
            r_ver_ihl <= n_ver_ihl;
            r_total   <= n_total;
            r_proto   <= n_proto;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_type    <= n_type;
            r_code    <= n_code;
            r_doff    <= n_doff;
        end
    end

endmodule

>>> hw/rtl/ehp_fifo.sv
// Short record queue between front end and back end
`timescale 1ns / 1ps

module ehp_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ehp_pkg::t_frame_rec i_rec,
    input  logic                i_pop,
    output ehp_pkg::t_frame_rec o_head,
    output ehp_pkg::t_q_stat    o_stat
);

    ehp_pkg::t_frame_rec             r_mem [ehp_pkg::QDepth];
    logic [ehp_pkg::QPtrW-1:0]       r_wr_ptr;
    logic [ehp_pkg::QPtrW-1:0]       r_rd_ptr;
    logic [ehp_pkg::QCntW-1:0]       r_count;
    logic [ehp_pkg::QCntW-1:0]       n_count;

    assign o_head           = r_mem[r_rd_ptr];
    assign o_stat.full      = (r_count == ehp_pkg::QCntW'(ehp_pkg::QDepth));
    assign o_stat.not_empty = (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

>>> hw/rtl/ehp_back.sv
// Back end: frame checks, result fields and output register
`timescale 1ns / 1ps

module ehp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ehp_pkg::t_q_stat    i_q_stat,
    input  ehp_pkg::t_frame_rec i_head,
    input  logic                i_ready,
    output logic                o_pop,
    output logic                o_valid,
    output logic [2:0]          o_status,
    output logic [7:0]          o_protocol,
    output logic [15:0]         o_source_port,
    output logic [15:0]         o_destination_port,
    output logic [7:0]          o_message_type,
    output logic [7:0]          o_message_code,
    output logic [7:0]          o_payload_offset,
    output logic [15:0]         o_payload_length
);

    logic [5:0]  w_ihl_b;
    logic [6:0]  w_t;
    logic [16:0] w_tot_end;
    logic [15:0] w_l4len;
    logic [5:0]  w_hdr;
    ehp_pkg::t_status w_st;

    logic              r_valid;
    ehp_pkg::t_status  r_status;
    logic [7:0]        r_protocol;
    logic [15:0]       r_src;
    logic [15:0]       r_dst;
    logic [7:0]        r_type;
    logic [7:0]        r_code;
    logic [7:0]        r_offset;
    logic [15:0]       r_length;

    assign o_pop = i_q_stat.not_empty && (!r_valid || i_ready);

    always_comb begin
        w_ihl_b   = {i_head.ver_ihl[3:0], 2'b00};
        w_t       = ehp_pkg::ETH_LEN + {1'b0, w_ihl_b};
        w_tot_end = 17'(ehp_pkg::ETH_LEN) + {1'b0, i_head.total};
        w_l4len   = i_head.total - {10'd0, w_ihl_b};
        w_hdr     = (i_head.proto == ehp_pkg::PROT_TCP) ? {i_head.doff, 2'b00}
                                                        : ehp_pkg::L4_SHORT;
        w_st      = ehp_pkg::ST_OK;
        if (i_head.flen < ehp_pkg::MIN_FRAME) begin
            w_st = ehp_pkg::ST_SHORT_FRAME;
        end else if (i_head.ver_ihl[7:4] != ehp_pkg::IP_V4) begin
            w_st = ehp_pkg::ST_NOT_V4;
        end else if (w_ihl_b < ehp_pkg::IP_MIN || i_head.flen < 18'(w_t)) begin
            w_st = ehp_pkg::ST_BAD_IHL;
        end else if (i_head.flen < 18'(w_tot_end) || i_head.total < 16'(w_ihl_b)) begin
            w_st = ehp_pkg::ST_BAD_TOTAL;
        end else if (i_head.proto == ehp_pkg::PROT_TCP) begin
            if (w_l4len < 16'(ehp_pkg::IP_MIN) || w_hdr < ehp_pkg::IP_MIN
                    || w_l4len < 16'(w_hdr)) begin
                w_st = ehp_pkg::ST_SHORT_L4;
            end
        end else if (i_head.proto == ehp_pkg::PROT_UDP
                || i_head.proto == ehp_pkg::PROT_ICMP) begin
            if (w_l4len < 16'(ehp_pkg::L4_SHORT)) begin
                w_st = ehp_pkg::ST_SHORT_L4;
            end
        end else begin
            w_st = ehp_pkg::ST_UNKNOWN_PROTO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status   <= w_st;
            r_protocol <= '0;
            r_src      <= '0;
            r_dst      <= '0;
            r_type     <= '0;
            r_code     <= '0;
            r_offset   <= '0;
            r_length   <= '0;
            if (w_st == ehp_pkg::ST_OK) begin
                r_protocol <= i_head.proto;
                if (i_head.proto == ehp_pkg::PROT_ICMP) begin
                    r_type <= i_head.mtype;
                    r_code <= i_head.mcode;
                end else begin
                    r_src <= i_head.src;
                    r_dst <= i_head.dst;
                end
                r_offset <= 8'(w_t) + 8'(w_hdr);
                r_length <= w_l4len - 16'(w_hdr);
            end
        end
    end

    assign o_valid            = r_valid;
    assign o_status           = r_status;
    assign o_protocol         = r_protocol;
    assign o_source_port      = r_src;
    assign o_destination_port = r_dst;
    assign o_message_type     = r_type;
    assign o_message_code     = r_code;
    assign o_payload_offset   = r_offset;
    assign o_payload_length   = r_length;

endmodule

>>> hw/rtl/eth_ipv4_l4_header_parser_top.sv
// Top level of the Ethernet/IPv4/L4 header parser
// Throughput: one byte beat per cycle while o_ready is high; a frame may be one byte.
// o_valid is registered: a frame's record passes the queue, then the output register.
// o_ready drops only while the two-entry record queue is full (output stalled).
// Reset: synchronous, active low; clears byte count, captured fields, queue
// and output valid.
`timescale 1ns / 1ps

module eth_ipv4_l4_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_protocol,
    output logic [15:0] o_source_port,
    output logic [15:0] o_destination_port,
    output logic [7:0]  o_message_type,
    output logic [7:0]  o_message_code,
    output logic [7:0]  o_payload_offset,
    output logic [15:0] o_payload_length
);

    ehp_pkg::t_q_stat    w_q_stat;
    ehp_pkg::t_frame_rec w_push_rec;
    ehp_pkg::t_frame_rec w_head;
    logic                w_push;
    logic                w_pop;

    ehp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_stat    (w_q_stat),
        .o_ready     (o_ready),
        .o_push      (w_push),
        .o_rec       (w_push_rec)
    );

    ehp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_push_rec),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    ehp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_stat           (w_q_stat),
        .i_head             (w_head),
        .i_ready            (i_ready),
        .o_pop              (w_pop),
        .o_valid            (o_valid),
        .o_status           (o_status),
        .o_protocol         (o_protocol),
        .o_source_port      (o_source_port),
        .o_destination_port (o_destination_port),
        .o_message_type     (o_message_type),
        .o_message_code     (o_message_code),
        .o_payload_offset   (o_payload_offset),
        .o_payload_length   (o_payload_length)
    );

endmodule

>>> hw/rtl/ehp_checker.sv
// Port-level assertion checker for the header parser, bound to the top level
`timescale 1ns / 1ps
`include "eth_ipv4_l4_header_parser_top_assert.svh"

module ehp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_last_byte,
    input logic        o_valid,
    input logic        i_ready,
    input logic [2:0]  o_status,
    input logic [7:0]  o_protocol,
    input logic [15:0] o_source_port,
    input logic [15:0] o_destination_port,
    input logic [7:0]  o_message_type,
    input logic [7:0]  o_message_code,
    input logic [7:0]  o_payload_offset,
    input logic [15:0] o_payload_length
);

    logic        w_stall;
    logic [82:0] w_beat;
    logic        w_rest_zero;
    logic        w_off_ok;

    assign w_stall     = o_valid && !i_ready;
    assign w_beat      = {o_status, o_protocol, o_source_port, o_destination_port,
                          o_message_type, o_message_code, o_payload_offset,
                          o_payload_length};
    assign w_rest_zero = (w_beat[79:0] == '0);
    assign w_off_ok    = (o_payload_offset >= 8'd42) && (o_payload_offset <= 8'd134);

    `EHP_ASSERT_CLK(a_out_hold, w_stall |=> o_valid && $stable(w_beat), "beat changed in stall")
    `EHP_ASSERT_CLK(a_status_range, o_valid |-> o_status <= ehp_pkg::ST_UNKNOWN_PROTO, "bad status")
    `EHP_ASSERT_CLK(a_err_zero, o_valid && o_status != ehp_pkg::ST_OK |-> w_rest_zero, "error beat nonzero")
    `EHP_ASSERT_CLK(a_ok_offset, o_valid && o_status == ehp_pkg::ST_OK |-> w_off_ok, "offset out of bounds")

endmodule

bind eth_ipv4_l4_header_parser_top ehp_checker u_ehp_checker (.*);
